// ===== rtl/core/ifs_pkg.sv =====
// Package for the image format sniffer: constants, format codes and shared types.
package ifs_pkg;

	// Number of leading file bytes that are kept for the signature checks.
	localparam int HDR_LEN = 12;
	localparam int CNT_W = $clog2(HDR_LEN + 1);
	localparam int HDR_BITS = 8 * HDR_LEN;

	// The PNG chunk walk starts at this byte offset.
	localparam logic [CNT_W-1:0] WALK_START = CNT_W'(8);

	// Signatures, first file byte in the most significant position.
	localparam logic [47:0] SIG_GIF87A = "GIF87a";
	localparam logic [47:0] SIG_GIF89A = "GIF89a";
	localparam logic [63:0] SIG_PNG = 64'h8950_4E47_0D0A_1A0A;
	localparam logic [31:0] SIG_RIFF = "RIFF";
	localparam logic [31:0] SIG_WEBP = "WEBP";
	localparam logic [15:0] SIG_BMP = "BM";

	// PNG chunk types that end the walk.
	localparam logic [31:0] TAG_ACTL = "acTL";
	localparam logic [31:0] TAG_IDAT = "IDAT";
	localparam logic [31:0] TAG_IEND = "IEND";

	// Bytes of CRC that follow the data of every chunk.
	localparam logic [32:0] CRC_LEN = 33'd4;

	// Result codes.
	typedef enum logic [2:0] {
		FMT_UNKNOWN = 3'd0,
		FMT_GIF     = 3'd1,
		FMT_PNG     = 3'd2,
		FMT_APNG    = 3'd3,
		FMT_WEBP    = 3'd4,
		FMT_BMP     = 3'd5
	} fmt_t;

	// One byte as it leaves the input register and updates the state.
	typedef struct packed {
		logic       step;
		logic       last;
		logic [7:0] data;
	} ifs_beat_t;

endpackage

// ===== rtl/core/ifs_in_if.sv =====
// Input channel: one file byte per item with its last-byte mark.
interface ifs_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] file_byte;
	logic       is_final;

	modport source (output valid, output file_byte, output is_final, input ready);
	modport sink (input valid, input file_byte, input is_final, output ready);
endinterface

// ===== rtl/core/ifs_out_if.sv =====
// Output channel: one format code per item.
interface ifs_out_if;
	logic       valid;
	logic       ready;
	logic [2:0] format_code;

	modport source (output valid, output format_code, input ready);
	modport sink (input valid, input format_code, output ready);
endinterface

// ===== rtl/core/ifs_walker.sv =====
// PNG chunk walker: collects chunk length and type, skips data and CRC, flags acTL.
module ifs_walker import ifs_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  ifs_beat_t beat,
	input  logic      walk_en,
	output logic      animated
);

	typedef enum logic [2:0] {
		PH_LEN  = 3'b001,
		PH_TYPE = 3'b010,
		PH_SKIP = 3'b100
	} phase_t;

	typedef enum logic [2:0] {
		VD_SEARCH = 3'b001,
		VD_ANIM   = 3'b010,
		VD_STILL  = 3'b100
	} verdict_t;

	localparam logic [1:0] OFF_LAST = 2'd3;

	phase_t      phase_q, phase_n;
	verdict_t    verdict_q, verdict_n;
	logic [1:0]  off_q, off_n;
	logic [31:0] len_q, len_n;
	logic [31:0] type_q, type_n;
	logic [32:0] skip_q, skip_n;
	logic [31:0] len_shift, type_shift;
	logic [32:0] skip_dec;
	logic        go;

	assign go = beat.step && walk_en && (verdict_q == VD_SEARCH);
	assign len_shift = {len_q[23:0], beat.data};
	assign type_shift = {type_q[23:0], beat.data};
	assign skip_dec = skip_q - {32'd0, (skip_q != 33'd0)};

	// Next walker state for the byte in flight.
	always_comb begin
		phase_n = phase_q;
		verdict_n = verdict_q;
		off_n = off_q;
		len_n = len_q;
		type_n = type_q;
		skip_n = skip_q;
		if (go) begin
			case (phase_q)
				PH_LEN: begin
					len_n = len_shift;
					if (off_q == OFF_LAST) begin
						off_n = 2'd0;
						phase_n = PH_TYPE;
					end else begin
						off_n = off_q + 2'd1;
					end
				end
				PH_TYPE: begin
					type_n = type_shift;
					if (off_q == OFF_LAST) begin
						off_n = 2'd0;
						if (type_shift == TAG_ACTL) begin
							verdict_n = VD_ANIM;
						end else if (type_shift == TAG_IDAT || type_shift == TAG_IEND) begin
							verdict_n = VD_STILL;
						end else begin
							skip_n = {1'b0, len_q} + CRC_LEN;
							phase_n = PH_SKIP;
						end
					end else begin
						off_n = off_q + 2'd1;
					end
				end
				PH_SKIP: begin
					skip_n = skip_dec;
					if (skip_dec == 33'd0) begin
						phase_n = PH_LEN;
						off_n = 2'd0;
						len_n = 32'd0;
						type_n = 32'd0;
					end
				end
				default: begin
					phase_n = PH_LEN;
				end
			endcase
		end
	end

	// The verdict includes the byte in flight, so the last byte counts.
	assign animated = (verdict_n == VD_ANIM);

	// State registers; the last byte of a file returns everything to reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_LEN;
			verdict_q <= VD_SEARCH;
			off_q <= 2'd0;
			len_q <= 32'd0;
			type_q <= 32'd0;
			skip_q <= 33'd0;
		end else if (beat.step && beat.last) begin
			phase_q <= PH_LEN;
			verdict_q <= VD_SEARCH;
			off_q <= 2'd0;
			len_q <= 32'd0;
			type_q <= 32'd0;
			skip_q <= 33'd0;
		end else if (go) begin
			phase_q <= phase_n;
			verdict_q <= verdict_n;
			off_q <= off_n;
			len_q <= len_n;
			type_q <= type_n;
			skip_q <= skip_n;
		end
	end

	// A settled verdict never changes until the file ends.
	a_verdict_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		(verdict_q != VD_SEARCH) && !(beat.step && beat.last) |=> $stable(verdict_q))
		else $error("walker verdict changed after it was settled");

	// The skip counter is only nonzero while skipping.
	a_skip_phase: assert property (@(posedge clk) disable iff (!arst_n)
		(skip_q != 33'd0) |-> (phase_q == PH_SKIP))
		else $error("skip count left over outside the skip phase");

	// The last byte of a file leaves the walker in its start state.
	a_end_clear: assert property (@(posedge clk) disable iff (!arst_n)
		beat.step && beat.last |=> (phase_q == PH_LEN) && (verdict_q == VD_SEARCH)
			&& (off_q == 2'd0))
		else $error("walker not cleared after the last byte");

endmodule

// ===== rtl/core/ifs_header.sv =====
// Header store and signature classifier over the first twelve file bytes.
module ifs_header import ifs_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  ifs_beat_t beat,
	input  logic      animated,
	output logic      walk_en,
	output fmt_t      fmt
);

	localparam logic [CNT_W-1:0] SEEN_FULL = CNT_W'(HDR_LEN);
	localparam logic [CNT_W-1:0] SEEN_LAST = CNT_W'(HDR_LEN - 1);

	logic [7:0]          hdr_q [HDR_LEN];
	logic [CNT_W-1:0]    seen_q;
	logic [HDR_BITS-1:0] hdr_vec;
	logic                full;

	// Header bytes are written once each, in file order.
	always_ff @(posedge clk) begin
		if (beat.step && (seen_q < SEEN_FULL)) begin
			hdr_q[seen_q] <= beat.data;
		end
	end

	// Byte count saturates at the header length and clears at end of file.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q <= '0;
		end else if (beat.step) begin
			if (beat.last) begin
				seen_q <= '0;
			end else if (seen_q < SEEN_FULL) begin
				seen_q <= seen_q + CNT_W'(1);
			end
		end
	end

	assign walk_en = (seen_q >= WALK_START);

	// Header as it stands after the byte in flight, first byte on top.
	always_comb begin
		for (int i = 0; i < HDR_LEN; i++) begin
			hdr_vec[HDR_BITS-1-8*i -: 8] = (seen_q == CNT_W'(i)) ? beat.data : hdr_q[i];
		end
	end

	assign full = (seen_q == SEEN_FULL) || (seen_q == SEEN_LAST);

	// Signature checks in priority order.
	always_comb begin
		if (!full) begin
			fmt = FMT_UNKNOWN;
		end else if (hdr_vec[HDR_BITS-1 -: 48] == SIG_GIF87A
				|| hdr_vec[HDR_BITS-1 -: 48] == SIG_GIF89A) begin
			fmt = FMT_GIF;
		end else if (hdr_vec[HDR_BITS-1 -: 64] == SIG_PNG) begin
			fmt = animated ? FMT_APNG : FMT_PNG;
		end else if (hdr_vec[HDR_BITS-1 -: 32] == SIG_RIFF && hdr_vec[31:0] == SIG_WEBP) begin
			fmt = FMT_WEBP;
		end else if (hdr_vec[HDR_BITS-1 -: 16] == SIG_BMP) begin
			fmt = FMT_BMP;
		end else begin
			fmt = FMT_UNKNOWN;
		end
	end

endmodule

// ===== rtl/core/image_format_sniffer_top.sv =====
// Top level of the image format sniffer: input register, state update, result register.
//
// The block takes one file byte per item and gives one format code on the item
// that carries the last-byte mark; other items give nothing. Each item waits in
// the input register until it moves on, when the state update and the result
// register take it, so a code is offered in the cycle after its last byte moves
// on, and a new byte can be taken in every cycle unless a last byte waits for a
// full result register. A code that waits at the output stalls only the next
// last byte; the result register is the only thing that can hold the stream.
// Codes: 0 unknown, 1 GIF, 2 PNG, 3 animated PNG, 4 WebP, 5 BMP. Files shorter
// than twelve bytes are unknown. After each last byte the block is ready for a
// new file with no gap.
module image_format_sniffer_top import ifs_pkg::*; (
	input logic clk,
	input logic arst_n,
	ifs_in_if.sink    in_ch,
	ifs_out_if.source out_ch
);

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       final_s1;
	logic       adv_s1;
	logic       out_valid_q;
	fmt_t       out_code_q;
	ifs_beat_t  beat;
	logic       walk_en;
	logic       animated;
	fmt_t       fmt;

	// A byte moves on unless it is a last byte and the result register is full.
	assign adv_s1 = valid_s1 && (!final_s1 || !out_valid_q || out_ch.ready);
	assign in_ch.ready = !valid_s1 || adv_s1;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.valid && in_ch.ready) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) begin
			byte_s1 <= in_ch.file_byte;
			final_s1 <= in_ch.is_final;
		end
	end

	assign beat = '{step: adv_s1, last: final_s1, data: byte_s1};

	ifs_header u_header (
		.clk      (clk),
		.arst_n   (arst_n),
		.beat     (beat),
		.animated (animated),
		.walk_en  (walk_en),
		.fmt      (fmt)
	);

	ifs_walker u_walker (
		.clk      (clk),
		.arst_n   (arst_n),
		.beat     (beat),
		.walk_en  (walk_en),
		.animated (animated)
	);

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1 && final_s1) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && final_s1) begin
			out_code_q <= fmt;
		end
	end

	assign out_ch.valid = out_valid_q;
	assign out_ch.format_code = out_code_q;

	// A last byte that moves on always leaves a result behind it.
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 && final_s1 |=> out_valid_q)
		else $error("last item moved on without a result");

	// A waiting result is never overwritten.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_ch.ready |-> !(adv_s1 && final_s1))
		else $error("pending result overwritten");

	// Only defined format codes are shown.
	a_code_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_code_q <= FMT_BMP))
		else $error("format code out of range");

endmodule
